// ===== sv/assert_macros.svh =====
// Assertion macros used by the glyph cache lookup top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge while out of reset
`define HGC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never holds while out of reset
`define HGC_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define HGC_ASSERT(label, clk, rst_n, prop, msg)
`define HGC_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== sv/hgc_pkg.sv =====
// Types, constants and helpers for the glyph cache lookup
`timescale 1ns / 1ps
package hgc_pkg;

  // Default geometry
  localparam int unsigned CACHE_ENTRIES = 4096;
  localparam int unsigned PROBE_LIMIT   = 8;

  // Key layout and hash constant
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned SLOT_W     = 12;
  localparam int unsigned SIZE_SHIFT = 24;
  localparam int unsigned FACE_SHIFT = 16;
  localparam logic [KEY_W-1:0] FIB_MULT = 32'd2654435761;

  // Request item
  typedef struct packed {
    logic [7:0]  size_px;
    logic        face;
    logic [15:0] glyph_id;
  } req_t;

  // Result item
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
  } rsp_t;

  // Build the 32-bit lookup key from a request
  function automatic logic [KEY_W-1:0] make_key(req_t req);
    logic [KEY_W-1:0] key;
    key = (KEY_W'(req.size_px) << SIZE_SHIFT)
        | (KEY_W'(req.face) << FACE_SHIFT)
        | KEY_W'(req.glyph_id);
    return key;
  endfunction

endpackage

// ===== sv/hgc_hash.sv =====
// Key formation and Fibonacci hash to a home slot, registered
`timescale 1ns / 1ps
module hgc_hash #(
  parameter int unsigned CACHE_ENTRIES = hgc_pkg::CACHE_ENTRIES
) (
  input  logic                         clk_i,
  input  logic                         load_i,
  input  hgc_pkg::req_t                req_i,
  output logic [hgc_pkg::KEY_W-1:0]    key_o,
  output logic [$clog2(CACHE_ENTRIES)-1:0] home_o
);

  localparam int unsigned IDX_W = $clog2(CACHE_ENTRIES);

  logic [hgc_pkg::KEY_W-1:0] key_d, key_q;
  logic [hgc_pkg::KEY_W-1:0] prod;
  logic [IDX_W-1:0]          home_d, home_q;

  // Multiply modulo 2^32, keep the low index bits
  always_comb begin
    key_d  = hgc_pkg::make_key(req_i);
    prod   = key_d * hgc_pkg::FIB_MULT;
    home_d = prod[IDX_W-1:0];
  end

  // Capture key and home slot on accept
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      key_q  <= key_d;
      home_q <= home_d;
    end
  end

  assign key_o  = key_q;
  assign home_o = home_q;

endmodule

// ===== sv/hgc_key_ram.sv =====
// Key store memory: one write port, one registered read port
`timescale 1ns / 1ps
module hgc_key_ram #(
  parameter int unsigned CACHE_ENTRIES = hgc_pkg::CACHE_ENTRIES
) (
  input  logic                             clk_i,
  input  logic                             rd_en_i,
  input  logic [$clog2(CACHE_ENTRIES)-1:0] rd_addr_i,
  output logic [hgc_pkg::KEY_W-1:0]        rd_data_o,
  input  logic                             wr_en_i,
  input  logic [$clog2(CACHE_ENTRIES)-1:0] wr_addr_i,
  input  logic [hgc_pkg::KEY_W-1:0]        wr_data_i
);

  logic [hgc_pkg::KEY_W-1:0] mem_q [CACHE_ENTRIES];
  logic [hgc_pkg::KEY_W-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/hashed_glyph_cache_lookup.sv =====
// Top level of the glyph cache tag store: probe sequencer and result register
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Glyph cache tag lookup. Each item (pixel size, face, glyph) is hashed to a home slot and
// up to PROBE_LIMIT consecutive slots of a CACHE_ENTRIES-deep key memory (a power of two)
// are read, one per cycle on its single read port; a matching key is a hit, otherwise the
// first empty slot, or the home slot when all probed slots are full, takes the key. One
// item is in work at a time: on accept its key and home slot are registered, then its
// probes are read and judged in turn until one decides it; the decided result goes to
// the output register when that is free. The result sits in an output register, so the
// next item can be taken while it waits. When an item is decided while the previous result
// still waits there, the block holds the new result and stalls its input until the output
// register frees. After reset the block zeroes the key memory one entry per cycle and
// accepts no item until every entry has been cleared.
module hashed_glyph_cache_lookup #(
  parameter int unsigned CACHE_ENTRIES = hgc_pkg::CACHE_ENTRIES,
  parameter int unsigned PROBE_LIMIT   = hgc_pkg::PROBE_LIMIT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  hgc_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output hgc_pkg::rsp_t out_data_o
);

  localparam int unsigned IDX_W  = $clog2(CACHE_ENTRIES);
  localparam int unsigned PRB_W  = $clog2(PROBE_LIMIT + 1);
  localparam int unsigned SLOT_W = hgc_pkg::SLOT_W;
  localparam int unsigned KEY_W  = hgc_pkg::KEY_W;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_PROBE = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e            state_d, state_q;
  logic [IDX_W-1:0]  clr_addr_d, clr_addr_q;
  logic [PRB_W-1:0]  iss_cnt_d, iss_cnt_q;
  logic              rd_vld_d, rd_vld_q;
  logic [PRB_W-1:0]  rd_prb_d, rd_prb_q;
  logic [IDX_W-1:0]  rd_idx_d, rd_idx_q;
  hgc_pkg::rsp_t     res_d, res_q;
  logic              out_valid_d, out_valid_q;
  hgc_pkg::rsp_t     out_data_d, out_data_q;

  logic              accept;
  logic              out_free;
  logic [KEY_W-1:0]  key;
  logic [IDX_W-1:0]  home;
  logic              issue;
  logic [IDX_W-1:0]  rd_addr;
  logic [KEY_W-1:0]  rd_data;
  logic              is_hit, is_empty, is_last, decide;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [KEY_W-1:0]  wr_data;
  logic [IDX_W-1:0]  slot_idx;
  logic [SLOT_W+IDX_W-1:0] slot_ext;
  hgc_pkg::rsp_t     result;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  hgc_hash #(
    .CACHE_ENTRIES(CACHE_ENTRIES)
  ) u_hash (
    .clk_i (clk_i),
    .load_i(accept),
    .req_i (in_data_i),
    .key_o (key),
    .home_o(home)
  );

  hgc_key_ram #(
    .CACHE_ENTRIES(CACHE_ENTRIES)
  ) u_ram (
    .clk_i    (clk_i),
    .rd_en_i  (issue),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  // Judge the probe whose data has come back: key compare before empty test
  always_comb begin
    is_hit   = rd_vld_q && (rd_data == key);
    is_empty = rd_vld_q && (rd_data == '0);
    is_last  = rd_vld_q && (rd_prb_q == PRB_W'(PROBE_LIMIT - 1));
    decide   = (state_q == ST_PROBE) && (is_hit || is_empty || is_last);
    issue    = (state_q == ST_PROBE) && !decide && (iss_cnt_q < PRB_W'(PROBE_LIMIT));
    rd_addr  = home + IDX_W'(iss_cnt_q);
  end

  // Form the result; a full probe window evicts the home slot
  always_comb begin
    slot_idx       = (is_hit || is_empty) ? rd_idx_q : home;
    slot_ext       = {{SLOT_W{1'b0}}, slot_idx};
    result.hit     = is_hit;
    result.slot    = slot_ext[SLOT_W-1:0];
    result.evicted = !is_hit && !is_empty;
  end

  // Memory write: clearing sweep, or install of a missed key
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot_idx;
    wr_data = key;
    if (state_q == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_q;
      wr_data = '0;
    end else if (decide && !is_hit) begin
      wr_en = 1'b1;
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    iss_cnt_d   = iss_cnt_q;
    rd_vld_d    = issue;
    rd_prb_d    = iss_cnt_q;
    rd_idx_d    = rd_addr;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_addr_d = clr_addr_q + 1'b1;
        if (&clr_addr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          iss_cnt_d = '0;
          state_d   = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (issue) begin
          iss_cnt_d = iss_cnt_q + 1'b1;
        end
        if (decide) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_data_d  = result;
            state_d     = ST_IDLE;
          end else begin
            res_d   = result;
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      iss_cnt_q   <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      iss_cnt_q   <= iss_cnt_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rd_prb_q   <= rd_prb_d;
    rd_idx_q   <= rd_idx_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Drop any read still in flight once the item is decided
  `HGC_ASSERT(a_drop_stale, clk_i, rst_ni, decide |=> !rd_vld_q, "stale probe data kept")
  // Returned data always belongs to a probe inside the window
  `HGC_ASSERT(a_prb_range, clk_i, rst_ni,
              rd_vld_q |-> (state_q == ST_PROBE && rd_prb_q < PRB_W'(PROBE_LIMIT)),
              "probe index out of window")
  // An accepted item starts probing from the home slot
  `HGC_ASSERT(a_start_probe, clk_i, rst_ni,
              accept |=> (state_q == ST_PROBE && iss_cnt_q == '0 && !rd_vld_q),
              "probe did not restart")
  // A hit never reports an eviction
  `HGC_NEVER(a_hit_evict, clk_i, rst_ni,
             out_valid_q && out_data_q.hit && out_data_q.evicted, "hit with eviction")

endmodule
